/* hdl/rau_pkg.sv */
`timescale 1ns / 1ps
package rau_pkg;

  localparam int unsigned DataWidth = 32;

  typedef enum logic [3:0] {
    OP_MAKE = 4'd0,
    OP_ADD  = 4'd1,
    OP_SUB  = 4'd2,
    OP_MUL  = 4'd3,
    OP_DIV  = 4'd4,
    OP_NEG  = 4'd5,
    OP_EQ   = 4'd6,
    OP_NE   = 4'd7,
    OP_LT   = 4'd8,
    OP_GT   = 4'd9,
    OP_LE   = 4'd10,
    OP_GE   = 4'd11
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_MUL,
    S_COMB,
    S_NORM,
    S_GCD,
    S_DIV,
    S_FINISH,
    S_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mul_start;
    logic comb;
    logic gcd_start;
    logic div_start;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic early;
    logic is_cmp;
    logic mul_done;
    logic gcd_done;
    logic div_done;
  } stat_t;

endpackage

/* hdl/rau_datapath.sv */
`timescale 1ns / 1ps
module rau_datapath
  import rau_pkg::*;
#(
  parameter int unsigned DW = DataWidth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  input  logic [3:0]        operation_i,
  input  logic [31:0]       a_num_i,
  input  logic [31:0]       a_den_i,
  input  logic [31:0]       b_num_i,
  input  logic [30:0]       b_den_i,
  output logic [31:0]       result_num_o,
  output logic [30:0]       result_den_o,
  output logic              compare_true_o,
  output logic [1:0]        status_o
);

  localparam int unsigned MW  = 2 * DW;
  localparam int unsigned MCW = $clog2(DW);
  localparam int unsigned DCW = $clog2(MW);

  logic [3:0]    op_q;
  logic          an_q, bn_q;
  logic [DW-1:0] am_q, ad_q, bm_q, bd_q;
  logic [1:0]    st_q;
  logic          early_q;

  logic [MW-1:0]  pa_q, pb_q, pc_q;
  logic [MW-1:0]  ca_q, cb_q, cc_q;
  logic [DW-1:0]  fa_q, fb_q, fc_q;
  logic [MCW-1:0] mcnt_q;
  logic           mbusy_q;

  logic [MW-1:0] x_q, y_q;
  logic          xn_q;
  logic          cmp_q;

  logic [MW-1:0]  gu_q, gv_q, g_q;
  logic [DCW-1:0] gk_q;
  logic           gbusy_q;

  logic [MW-1:0]  nq_q, nr_q, dq_q, dr_q;
  logic [DCW-1:0] dcnt_q;
  logic           dbusy_q;

  logic [DW-1:0] in_an, in_ad, in_bn, in_bd;
  logic          an_neg, ad_neg;
  logic [DW-1:0] an_mag, ad_mag, bn_mag;

  always_comb begin
    in_an  = a_num_i[DW-1:0];
    in_ad  = a_den_i[DW-1:0];
    in_bn  = b_num_i[DW-1:0];
    in_bd  = {1'b0, b_den_i[DW-2:0]};
    an_neg = in_an[DW-1];
    ad_neg = in_ad[DW-1];
    an_mag = an_neg ? (~in_an + 1'b1) : in_an;
    ad_mag = ad_neg ? (~in_ad + 1'b1) : in_ad;
    bn_mag = in_bn[DW-1] ? (~in_bn + 1'b1) : in_bn;
  end

  logic [MW-1:0] lim;
  assign lim = {{(DW + 1){1'b0}}, {(DW - 1){1'b1}}};

  // Factors of the numerator and denominator products.
  logic [DW-1:0] fa_sel, fc_sel;
  always_comb begin
    case (op_q)
      OP_MAKE, OP_NEG: begin
        fa_sel = DW'(1);
        fc_sel = DW'(1);
      end
      OP_MUL: begin
        fa_sel = bm_q;
        fc_sel = bd_q;
      end
      OP_DIV: begin
        fa_sel = bd_q;
        fc_sel = bm_q;
      end
      default: begin
        fa_sel = bd_q;
        fc_sel = bd_q;
      end
    endcase
  end

  logic          n2, sum_neg, cmp_r;
  logic [MW-1:0] sum_m, pa_s, pb_s;
  always_comb begin
    n2 = (op_q == OP_SUB) ? !bn_q : bn_q;
    if (an_q == n2) begin
      sum_m   = pa_q + pb_q;
      sum_neg = an_q;
    end else if (pa_q >= pb_q) begin
      sum_m   = pa_q - pb_q;
      sum_neg = an_q;
    end else begin
      sum_m   = pb_q - pa_q;
      sum_neg = n2;
    end
    pa_s = an_q ? (~pa_q + 1'b1) : pa_q;
    pb_s = bn_q ? (~pb_q + 1'b1) : pb_q;
    case (op_q)
      OP_EQ:   cmp_r = (pa_s == pb_s);
      OP_NE:   cmp_r = (pa_s != pb_s);
      OP_LT:   cmp_r = ($signed(pa_s) < $signed(pb_s));
      OP_GT:   cmp_r = ($signed(pa_s) > $signed(pb_s));
      OP_LE:   cmp_r = ($signed(pa_s) <= $signed(pb_s));
      OP_GE:   cmp_r = ($signed(pa_s) >= $signed(pb_s));
      default: cmp_r = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gbusy_q <= 1'b0;
      dbusy_q <= 1'b0;
      mbusy_q <= 1'b0;
    end else begin
      if (cmd_i.gcd_start) begin
        gbusy_q <= 1'b1;
      end else if (gbusy_q && (gu_q == '0 || gv_q == '0)) begin
        gbusy_q <= 1'b0;
      end
      if (cmd_i.div_start) begin
        dbusy_q <= 1'b1;
      end else if (dbusy_q && dcnt_q == DCW'(MW - 1)) begin
        dbusy_q <= 1'b0;
      end
      if (cmd_i.mul_start) begin
        mbusy_q <= 1'b1;
      end else if (mbusy_q && mcnt_q == MCW'(DW - 1)) begin
        mbusy_q <= 1'b0;
      end
    end
  end

  logic [MW-1:0] nr_sh, dr_sh;
  assign nr_sh = {nr_q[MW-2:0], nq_q[MW-1]};
  assign dr_sh = {dr_q[MW-2:0], dq_q[MW-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= operation_i;
      an_q    <= (an_neg != ad_neg) && (an_mag != '0);
      am_q    <= an_mag;
      ad_q    <= ad_mag;
      bn_q    <= in_bn[DW-1];
      bm_q    <= bn_mag;
      bd_q    <= in_bd;
      early_q <= 1'b1;
      st_q    <= ST_OK;
      if (operation_i > OP_GE) begin
        st_q <= ST_OK;
      end else if (in_ad == '0 ||
                   (operation_i != OP_MAKE && operation_i != OP_NEG && in_bd == '0)) begin
        st_q <= ST_ZERO_DEN;
      end else if (operation_i == OP_DIV && in_bn == '0) begin
        st_q <= ST_DIV_ZERO;
      end else begin
        early_q <= 1'b0;
      end
    end
    // Three shift-add products run side by side.
    if (cmd_i.mul_start) begin
      mcnt_q <= '0;
      pa_q   <= '0;
      pb_q   <= '0;
      pc_q   <= '0;
      ca_q   <= MW'(am_q);
      fa_q   <= fa_sel;
      cb_q   <= MW'(bm_q);
      fb_q   <= ad_q;
      cc_q   <= MW'(ad_q);
      fc_q   <= fc_sel;
    end else if (mbusy_q) begin
      mcnt_q <= mcnt_q + 1'b1;
      if (fa_q[0]) begin
        pa_q <= pa_q + ca_q;
      end
      if (fb_q[0]) begin
        pb_q <= pb_q + cb_q;
      end
      if (fc_q[0]) begin
        pc_q <= pc_q + cc_q;
      end
      ca_q <= ca_q << 1;
      cb_q <= cb_q << 1;
      cc_q <= cc_q << 1;
      fa_q <= fa_q >> 1;
      fb_q <= fb_q >> 1;
      fc_q <= fc_q >> 1;
    end
    if (cmd_i.comb) begin
      y_q   <= pc_q;
      cmp_q <= cmp_r;
      case (op_q)
        OP_ADD, OP_SUB: begin
          x_q  <= sum_m;
          xn_q <= sum_neg;
        end
        OP_NEG: begin
          x_q  <= pa_q;
          xn_q <= !an_q;
        end
        OP_MUL, OP_DIV: begin
          x_q  <= pa_q;
          xn_q <= (an_q != bn_q);
        end
        default: begin
          x_q  <= pa_q;
          xn_q <= an_q;
        end
      endcase
    end
    if (cmd_i.gcd_start) begin
      gu_q <= x_q;
      gv_q <= y_q;
      gk_q <= '0;
    end else if (gbusy_q && gu_q != '0 && gv_q != '0) begin
      if (!gu_q[0] && !gv_q[0]) begin
        gu_q <= gu_q >> 1;
        gv_q <= gv_q >> 1;
        gk_q <= gk_q + 1'b1;
      end else if (!gu_q[0]) begin
        gu_q <= gu_q >> 1;
      end else if (!gv_q[0]) begin
        gv_q <= gv_q >> 1;
      end else if (gu_q >= gv_q) begin
        gu_q <= (gu_q - gv_q) >> 1;
      end else begin
        gv_q <= (gv_q - gu_q) >> 1;
      end
    end else if (gbusy_q) begin
      g_q <= (gu_q | gv_q) << gk_q;
    end
    // Two restoring dividers share the gcd as divisor.
    if (cmd_i.div_start) begin
      nq_q   <= x_q;
      nr_q   <= '0;
      dq_q   <= y_q;
      dr_q   <= '0;
      dcnt_q <= '0;
    end else if (dbusy_q) begin
      dcnt_q <= dcnt_q + 1'b1;
      if (nr_sh >= g_q) begin
        nr_q <= nr_sh - g_q;
        nq_q <= {nq_q[MW-2:0], 1'b1};
      end else begin
        nr_q <= nr_sh;
        nq_q <= {nq_q[MW-2:0], 1'b0};
      end
      if (dr_sh >= g_q) begin
        dr_q <= dr_sh - g_q;
        dq_q <= {dq_q[MW-2:0], 1'b1};
      end else begin
        dr_q <= dr_sh;
        dq_q <= {dq_q[MW-2:0], 1'b0};
      end
    end
  end

  assign stat_o.early    = early_q;
  assign stat_o.is_cmp   = (op_q >= OP_EQ);
  assign stat_o.mul_done = !mbusy_q;
  assign stat_o.gcd_done = !gbusy_q;
  assign stat_o.div_done = !dbusy_q;

  logic          res_neg;
  logic          ovf;
  logic [MW-1:0] num_s;
  always_comb begin
    res_neg = xn_q && (nq_q != '0);
    ovf     = (dq_q > lim) || (nq_q > lim + MW'(res_neg));
    num_s   = res_neg ? (~nq_q + 1'b1) : nq_q;
  end

  logic [31:0] rn_q;
  logic [30:0] rd_q;
  logic        rc_q;
  logic [1:0]  rs_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rn_q <= '0;
      rd_q <= '0;
      rc_q <= 1'b0;
      rs_q <= ST_OK;
    end else if (cmd_i.finish) begin
      rn_q <= '0;
      rd_q <= '0;
      rc_q <= 1'b0;
      rs_q <= st_q;
      if (!early_q) begin
        if (op_q >= OP_EQ) begin
          rc_q <= cmp_q;
        end else if (ovf) begin
          rs_q <= ST_OVERFLOW;
        end else begin
          rn_q <= 32'($signed(num_s[DW-1:0]));
          rd_q <= 31'(dq_q[DW-2:0]);
        end
      end
    end
  end

  assign result_num_o   = rn_q;
  assign result_den_o   = rd_q;
  assign compare_true_o = rc_q;
  assign status_o       = rs_q;

endmodule

/* hdl/rau_controller.sv */
`timescale 1ns / 1ps
module rau_controller
  import rau_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  output logic  busy_o,
  output logic  done_o,
  output cmd_t  cmd_o,
  input  stat_t stat_i
);

  state_e state_q, state_d;
  logic   done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_FINISH);
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_LOAD;
        end
      end
      S_LOAD: begin
        if (stat_i.early) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.mul_start = 1'b1;
          state_d         = S_MUL;
        end
      end
      S_MUL: begin
        if (stat_i.mul_done) begin
          state_d = S_COMB;
        end
      end
      S_COMB: begin
        cmd_o.comb = 1'b1;
        state_d    = stat_i.is_cmp ? S_FINISH : S_NORM;
      end
      S_NORM: begin
        cmd_o.gcd_start = 1'b1;
        state_d         = S_GCD;
      end
      S_GCD: begin
        if (stat_i.gcd_done) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

`ifndef ASSERT_OFF
  a_done_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q) == S_FINISH) else $error("done without finish");
  a_busy_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("start not taken");
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
`endif

endmodule

/* hdl/rational_arithmetic_unit.sv */
`timescale 1ns / 1ps
// Channel   Handshake     Payload
// command   start/busy    operation_i, a_num_i, a_den_i, b_num_i, b_den_i
// result    done_o        result_num_o, result_den_o, compare_true_o, status_o
// One word is taken at a rising edge with start high and busy low.
// A fraction operation holds busy through the shift-add products, the binary
// gcd and the restoring dividers. Comparisons skip the gcd and the dividers,
// and flagged words skip all three steps; the result strobe lasts one cycle,
// in the last busy cycle. A new word can be taken at the earliest in the
// cycle after the strobe. Reset clears the controller and the result
// registers; the receiver cannot stall the unit.
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DataWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  operation_i,
  input  logic [31:0] a_num_i,
  input  logic [31:0] a_den_i,
  input  logic [31:0] b_num_i,
  input  logic [30:0] b_den_i,
  output logic        done_o,
  output logic [31:0] result_num_o,
  output logic [30:0] result_den_o,
  output logic        compare_true_o,
  output logic [1:0]  status_o
);

  cmd_t  cmd;
  stat_t stat;

  rau_controller u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (busy),
    .done_o (done_o),
    .cmd_o  (cmd),
    .stat_i (stat)
  );

  rau_datapath #(.DW(DATA_WIDTH)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .operation_i   (operation_i),
    .a_num_i       (a_num_i),
    .a_den_i       (a_den_i),
    .b_num_i       (b_num_i),
    .b_den_i       (b_den_i),
    .result_num_o  (result_num_o),
    .result_den_o  (result_den_o),
    .compare_true_o(compare_true_o),
    .status_o      (status_o)
  );

endmodule

/* tb/rational_arithmetic_unit_test.sv */
`timescale 1ns / 1ps
module rational_arithmetic_unit_test
  import rau_pkg::*;
();

  typedef struct {
    logic [31:0] num;
    logic [30:0] den;
    logic        cmp;
    logic [1:0]  status;
  } frac_word_t;

  // Exact rational predictor with an ordered store of pending answers.
  class fraction_scoreboard;
    frac_word_t pending[$];
    int unsigned errors;
    int unsigned checked;

    function longint unsigned gcd64(longint unsigned x, longint unsigned y);
      longint unsigned t;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      return x;
    endfunction

    function frac_word_t reduce(bit nneg, longint unsigned nmag, bit dneg,
                                longint unsigned dmag);
      frac_word_t w;
      longint unsigned g;
      longint unsigned lim;
      bit neg;
      lim = 64'h7fff_ffff;
      neg = (nneg != dneg) && nmag != 0;
      g = gcd64(nmag, dmag);
      nmag = nmag / g;
      dmag = dmag / g;
      w = '{32'd0, 31'd0, 1'b0, ST_OK};
      if (dmag > lim || nmag > lim + (neg ? 1 : 0)) begin
        w.status = ST_OVERFLOW;
      end else begin
        w.num = neg ? -nmag[31:0] : nmag[31:0];
        w.den = dmag[30:0];
      end
      return w;
    endfunction

    function void note_command(logic [3:0] op, logic [31:0] an, logic [31:0] ad,
                               logic [31:0] bn, logic [30:0] bd);
      frac_word_t w;
      longint sa, sd, sb, x, y;
      longint unsigned am, dm, bm, bdu, g, lcm, t1, t2, rm;
      bit aneg, bneg, n2, rn, r;
      w = '{32'd0, 31'd0, 1'b0, ST_OK};
      sa = longint'(signed'(an));
      sd = longint'(signed'(ad));
      sb = longint'(signed'(bn));
      bdu = bd;
      if (op > OP_GE) begin
        pending.push_back(w);
        return;
      end
      if (sd == 0 || (op != OP_MAKE && op != OP_NEG && bdu == 0)) begin
        w.status = ST_ZERO_DEN;
        pending.push_back(w);
        return;
      end
      aneg = sa < 0;
      am = aneg ? -sa : sa;
      if (sd < 0) aneg = !aneg && am != 0;
      dm = sd < 0 ? -sd : sd;
      bneg = sb < 0;
      bm = bneg ? -sb : sb;
      case (op)
        OP_MAKE: w = reduce(aneg, am, 1'b0, dm);
        OP_NEG: w = reduce(!aneg && am != 0, am, 1'b0, dm);
        OP_ADD, OP_SUB: begin
          g = gcd64(dm, bdu);
          lcm = dm / g * bdu;
          t1 = am * (bdu / g);
          t2 = bm * (dm / g);
          n2 = (op == OP_SUB) ? !bneg : bneg;
          if (aneg == n2) begin
            rn = aneg;
            rm = t1 + t2;
          end else if (t1 >= t2) begin
            rn = aneg;
            rm = t1 - t2;
          end else begin
            rn = n2;
            rm = t2 - t1;
          end
          w = reduce(rn, rm, 1'b0, lcm);
        end
        OP_MUL: w = reduce(aneg != bneg, am * bm, 1'b0, dm * bdu);
        OP_DIV: begin
          if (bm == 0) w.status = ST_DIV_ZERO;
          else w = reduce(aneg, am * bdu, bneg, dm * bm);
        end
        default: begin
          x = (aneg ? -longint'(am) : longint'(am)) * longint'(bdu);
          y = sb * longint'(dm);
          case (op)
            OP_EQ: r = x == y;
            OP_NE: r = x != y;
            OP_LT: r = x < y;
            OP_GT: r = x > y;
            OP_LE: r = x <= y;
            default: r = x >= y;
          endcase
          w.cmp = r;
        end
      endcase
      pending.push_back(w);
    endfunction

    function void check_result(logic [31:0] num, logic [30:0] den, logic cmp,
                               logic [1:0] status);
      frac_word_t e;
      if (pending.size() == 0) begin
        $error("result word with no command outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (num !== e.num) begin
        $error("result_num expected %0d got %0d", $signed(e.num), $signed(num));
        errors++;
      end
      if (den !== e.den) begin
        $error("result_den expected %0d got %0d", e.den, den);
        errors++;
      end
      if (cmp !== e.cmp) begin
        $error("compare_true expected %0b got %0b", e.cmp, cmp);
        errors++;
      end
      if (status !== e.status) begin
        $error("status expected %0d got %0d", e.status, status);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [3:0]  operation_i = '0;
  logic [31:0] a_num_i = '0;
  logic [31:0] a_den_i = '0;
  logic [31:0] b_num_i = '0;
  logic [30:0] b_den_i = '0;
  logic        done_o;
  logic [31:0] result_num_o;
  logic [30:0] result_den_o;
  logic        compare_true_o;
  logic [1:0]  status_o;

  fraction_scoreboard board = new();
  int unsigned gap_pct;
  int unsigned sent;

  rational_arithmetic_unit u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .operation_i(operation_i),
    .a_num_i(a_num_i),
    .a_den_i(a_den_i),
    .b_num_i(b_num_i),
    .b_den_i(b_den_i),
    .done_o(done_o),
    .result_num_o(result_num_o),
    .result_den_o(result_den_o),
    .compare_true_o(compare_true_o),
    .status_o(status_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) begin
      board.note_command(operation_i, a_num_i, a_den_i, b_num_i, b_den_i);
    end
    if (rst_ni && done_o) begin
      board.check_result(result_num_o, result_den_o, compare_true_o, status_o);
    end
  end

  task automatic send_word(logic [3:0] op, logic [31:0] an, logic [31:0] ad,
                           logic [31:0] bn, logic [30:0] bd);
    while (gap_pct != 0 && $urandom_range(99, 0) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    operation_i <= op;
    a_num_i <= an;
    a_den_i <= ad;
    b_num_i <= bn;
    b_den_i <= bd;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5, 0))
      0: return $urandom_range(9, 0) - 5;
      1: return $urandom_range(1000, 0) - 500;
      2: return {{16{1'b0}}, 16'($urandom)};
      3: return $urandom_range(3, 0) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_den();
    logic [31:0] d;
    d = pick_value();
    if ($urandom_range(19, 0) == 0) d = 32'd0;
    else if (d == 0) d = 32'd1;
    return d;
  endfunction

  task automatic random_words(int unsigned count);
    logic [31:0] ad, bd;
    logic [3:0] op;
    repeat (count) begin
      op = $urandom_range(15, 0) < 14 ? 4'($urandom_range(11, 0)) : 4'($urandom);
      ad = pick_den();
      if (op != OP_MAKE && $urandom_range(9, 0) != 0 && $signed(ad) < 0) ad = -ad;
      bd = pick_den();
      if (bd[30:0] == 0 && $urandom_range(3, 0) != 0) bd = 32'd1;
      send_word(op, pick_value(), ad, pick_value(), bd[30:0]);
    end
  endtask

  initial begin
    gap_pct = 0;
    sent = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_word(OP_MAKE, 32'd6, -32'd4, 32'd0, 31'd1);
    send_word(OP_MAKE, 32'd5, 32'd0, 32'd0, 31'd1);
    send_word(OP_MAKE, 32'h8000_0000, -32'd1, 32'd0, 31'd1);
    send_word(OP_MAKE, 32'd0, -32'd7, 32'd0, 31'd1);
    send_word(OP_MAKE, 32'h8000_0000, 32'h8000_0000, 32'd0, 31'd1);
    send_word(OP_ADD, 32'd1, 32'd6, 32'd1, 31'd10);
    send_word(OP_ADD, 32'h7fff_ffff, 32'd1, 32'd1, 31'd1);
    send_word(OP_SUB, 32'd1, 32'd3, 32'd1, 31'd3);
    send_word(OP_SUB, 32'h8000_0000, 32'd1, 32'h7fff_ffff, 31'h7fff_ffff);
    send_word(OP_MUL, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff);
    send_word(OP_MUL, 32'd3, 32'd4, 32'd8, 31'd9);
    send_word(OP_DIV, 32'd3, 32'd4, 32'd0, 31'd9);
    send_word(OP_DIV, 32'd3, 32'd4, -32'd6, 31'd7);
    send_word(OP_NEG, 32'h8000_0000, 32'd1, 32'd0, 31'd1);
    send_word(OP_NEG, 32'd2, 32'd0, 32'd0, 31'd0);
    send_word(OP_EQ, 32'd1, 32'd2, 32'd2, 31'd4);
    send_word(OP_NE, 32'd1, 32'd2, 32'd2, 31'd4);
    send_word(OP_LT, 32'h8000_0000, 32'd1, 32'h7fff_ffff, 31'd1);
    send_word(OP_GT, 32'h7fff_ffff, 32'd1, 32'h8000_0000, 31'h7fff_ffff);
    send_word(OP_LE, -32'd1, -32'd2, 32'd1, 31'd2);
    send_word(OP_GE, 32'd1, 32'd3, 32'd1, 31'd2);
    send_word(OP_EQ, 32'd1, 32'd3, 32'd1, 31'd0);
    send_word(4'd12, 32'd1, 32'd1, 32'd1, 31'd1);
    send_word(4'd15, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 31'h7fff_ffff);
    gap_pct = 7;
    random_words(460);
    gap_pct = 80;
    random_words(460);
    gap_pct = 0;
    random_words(460);
    start <= 1'b0;
    fork
      begin
        while (board.pending.size() != 0) @(posedge clk_i);
        repeat (300) @(posedge clk_i);
      end
      begin
        repeat (100000) @(posedge clk_i);
        $error("results still outstanding at drain limit");
        board.errors++;
      end
    join_any
    disable fork;
    $display("Sent %0d command words and checked %0d result words.", sent, board.checked);
    $display("Covered all operations, flagged cases and three sender idle profiles.");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Verification failed");
    $finish;
  end

endmodule

/* rational_arithmetic_unit.f */
hdl/rau_pkg.sv
hdl/rau_datapath.sv
hdl/rau_controller.sv
hdl/rational_arithmetic_unit.sv
tb/rational_arithmetic_unit_test.sv
